// ===== hw/rtl/pabc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pabc_pkg: shared types and constants for the polygon area/bounds core
// Fixed width of the area result and the per-word control flags of the product stage.
// ----------------------------------------------------------------------------
package pabc_pkg;

  localparam int AREA_BITS = 54;

  // vertex position flags carried with a word into the accumulate stage
  typedef struct packed {
    logic n0;     // first vertex of the polygon
    logic n2;     // third vertex: defines the reference turn sign
    logic n3;     // fourth or later vertex: checked against reference
    logic last;   // final vertex
    logic close;  // final vertex of a polygon with a legal vertex count
  } pabc_flags_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pabc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pabc_if: vertex and result channels of the polygon area/bounds core
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pabc_in_if #(
  parameter int COORD_BITS = 20
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vx;
  logic signed [COORD_BITS-1:0] vy;
  logic                         last_vertex;

  modport source (output valid, output vx, output vy, output last_vertex, input ready);
  modport sink   (input valid, input vx, input vy, input last_vertex, output ready);
endinterface

interface pabc_out_if import pabc_pkg::*; #(
  parameter int COORD_BITS = 20
) ();
  logic                         valid;
  logic                         ready;
  logic signed [AREA_BITS-1:0]  twice_area;
  logic signed [COORD_BITS-1:0] min_x;
  logic signed [COORD_BITS-1:0] min_y;
  logic        [COORD_BITS-1:0] box_width;
  logic        [COORD_BITS-1:0] box_height;
  logic                         convex;
  logic                         valid_res;

  modport source (output valid, output twice_area, output min_x, output min_y,
                  output box_width, output box_height, output convex,
                  output valid_res, input ready);
  modport sink   (input valid, input twice_area, input min_x, input min_y,
                  input box_width, input box_height, input convex,
                  input valid_res, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/polygon_area_bounds_convexity_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// polygon_area_bounds_convexity_core: streaming polygon measurements
// Shoelace area (doubled), bounding box and convexity of one closed polygon.
// ----------------------------------------------------------------------------
// Vertices stream in one word per clock, last_vertex marking the end of a
// polygon; the core takes a new vertex every cycle with no gaps between
// polygons while no result is held. One result word leaves per polygon from
// the result register, behind the input and product registers; a result
// held by out_ch.ready stalls the last vertex in the product stage and,
// behind it, the input. The product stage holds eight (COORD_BITS+1)-bit
// signed multipliers that all work on each vertex. A polygon with fewer
// than three or more than MAX_VERTICES vertices yields valid_res=0 with all
// other result fields zero. twice_area is negative for counterclockwise order.
module polygon_area_bounds_convexity_core import pabc_pkg::*; #(
  parameter int COORD_BITS   = 20,
  parameter int MAX_VERTICES = 4096
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  pabc_in_if.sink       in_ch,
  pabc_out_if.source    out_ch
);

  localparam int SW    = COORD_BITS + 1;
  localparam int PW    = 2 * COORD_BITS + 2;
  localparam int CW    = PW + 1;
  localparam int CNT_W = $clog2(MAX_VERTICES + 2);

  // input register
  logic                         a_vld_r;
  logic signed [COORD_BITS-1:0] a_x_r, a_y_r;
  logic                         a_last_r;

  // vertex history and bounding box
  logic signed [COORD_BITS-1:0] first_x_r, first_y_r, second_x_r, second_y_r;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r, pp_x_r, pp_y_r;
  logic signed [COORD_BITS-1:0] minx_r, maxx_r, miny_r, maxy_r;
  logic signed [COORD_BITS-1:0] minx_nxt, maxx_nxt, miny_nxt, maxy_nxt;
  logic        [CNT_W-1:0]      cnt_r, cnt_inc, cnt_nxt;

  // product register
  logic                         b_vld_r;
  pabc_flags_t                  b_flags_r, a_flags;
  logic signed [PW-1:0]         b_e1_r, b_e2_r;
  logic signed [PW-1:0]         b_c1a_r, b_c1b_r, b_c2a_r, b_c2b_r, b_c3a_r, b_c3b_r;
  logic signed [COORD_BITS-1:0] b_minx_r, b_maxx_r, b_miny_r, b_maxy_r;

  // running polygon state
  logic signed [AREA_BITS-1:0]  area_r, area_nxt, area_fin;
  logic                         ftp_r, ftp_nxt, same_r, same_nxt, same_fin;

  // result register
  logic                         o_vld_r;
  logic signed [AREA_BITS-1:0]  o_area_r;
  logic signed [COORD_BITS-1:0] o_minx_r, o_miny_r;
  logic        [COORD_BITS-1:0] o_w_r, o_h_r;
  logic                         o_convex_r, o_valid_r;

  logic                         o_free, b_adv, b_ready, a_adv;
  logic                         a_n0, a_n1, a_n2, res_ok;

  // A-side operands
  logic signed [SW-1:0] ex_s, ey_d, cx_s, cy_d;
  logic signed [SW-1:0] d_ppx, d_ppy, d_pcx, d_pcy, d_cfx, d_cfy, d_fsx, d_fsy;

  // accumulate-side
  logic signed [CW-1:0] zc1, zc2, zc3;
  logic                 pos1, pos2, pos3;

  // ---- handshake ----
  assign o_free      = !o_vld_r || out_ch.ready;
  assign b_adv       = b_vld_r && (!b_flags_r.last || o_free);
  assign b_ready     = !b_vld_r || b_adv;
  assign a_adv       = a_vld_r && b_ready;
  assign in_ch.ready = !a_vld_r || a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      a_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      a_x_r    <= in_ch.vx;
      a_y_r    <= in_ch.vy;
      a_last_r <= in_ch.last_vertex;
    end
  end

  // ---- vertex stage ----
  assign a_n0    = (cnt_r == CNT_W'(0));
  assign a_n1    = (cnt_r == CNT_W'(1));
  assign a_n2    = (cnt_r == CNT_W'(2));
  assign cnt_inc = (cnt_r <= CNT_W'(MAX_VERTICES)) ? cnt_r + CNT_W'(1) : cnt_r;
  assign cnt_nxt = a_last_r ? '0 : cnt_inc;
  assign res_ok  = (cnt_inc >= CNT_W'(3)) && (cnt_inc <= CNT_W'(MAX_VERTICES));

  assign a_flags.n0    = a_n0;
  assign a_flags.n2    = a_n2;
  assign a_flags.n3    = !a_n0 && !a_n1 && !a_n2;
  assign a_flags.last  = a_last_r;
  assign a_flags.close = a_last_r && res_ok;

  assign minx_nxt = (a_n0 || a_x_r < minx_r) ? a_x_r : minx_r;
  assign maxx_nxt = (a_n0 || a_x_r > maxx_r) ? a_x_r : maxx_r;
  assign miny_nxt = (a_n0 || a_y_r < miny_r) ? a_y_r : miny_r;
  assign maxy_nxt = (a_n0 || a_y_r > maxy_r) ? a_y_r : maxy_r;

  assign ex_s  = SW'(prev_x_r) + SW'(a_x_r);
  assign ey_d  = SW'(prev_y_r) - SW'(a_y_r);
  assign cx_s  = SW'(a_x_r) + SW'(first_x_r);
  assign cy_d  = SW'(a_y_r) - SW'(first_y_r);
  assign d_ppx = SW'(prev_x_r) - SW'(pp_x_r);
  assign d_ppy = SW'(prev_y_r) - SW'(pp_y_r);
  assign d_pcx = SW'(a_x_r) - SW'(prev_x_r);
  assign d_pcy = SW'(a_y_r) - SW'(prev_y_r);
  assign d_cfx = SW'(first_x_r) - SW'(a_x_r);
  assign d_cfy = SW'(first_y_r) - SW'(a_y_r);
  assign d_fsx = SW'(second_x_r) - SW'(first_x_r);
  assign d_fsy = SW'(second_y_r) - SW'(first_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (a_adv) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      if (a_n0) begin
        first_x_r <= a_x_r;
        first_y_r <= a_y_r;
      end
      if (a_n1) begin
        second_x_r <= a_x_r;
        second_y_r <= a_y_r;
      end
      pp_x_r   <= prev_x_r;
      pp_y_r   <= prev_y_r;
      prev_x_r <= a_x_r;
      prev_y_r <= a_y_r;
      minx_r   <= minx_nxt;
      maxx_r   <= maxx_nxt;
      miny_r   <= miny_nxt;
      maxy_r   <= maxy_nxt;
    end
  end

  // ---- product register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_ready) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_flags_r <= a_flags;
      b_e1_r    <= ex_s * ey_d;
      b_e2_r    <= cx_s * cy_d;
      b_c1a_r   <= d_ppx * d_pcy;
      b_c1b_r   <= d_ppy * d_pcx;
      b_c2a_r   <= d_pcx * d_cfy;
      b_c2b_r   <= d_pcy * d_cfx;
      b_c3a_r   <= d_cfx * d_fsy;
      b_c3b_r   <= d_cfy * d_fsx;
      b_minx_r  <= minx_nxt;
      b_maxx_r  <= maxx_nxt;
      b_miny_r  <= miny_nxt;
      b_maxy_r  <= maxy_nxt;
    end
  end

  // ---- accumulate stage ----
  assign zc1  = CW'(b_c1a_r) - CW'(b_c1b_r);
  assign zc2  = CW'(b_c2a_r) - CW'(b_c2b_r);
  assign zc3  = CW'(b_c3a_r) - CW'(b_c3b_r);
  assign pos1 = !zc1[CW-1] && (zc1 != '0);
  assign pos2 = !zc2[CW-1] && (zc2 != '0);
  assign pos3 = !zc3[CW-1] && (zc3 != '0);

  assign ftp_nxt  = b_flags_r.n2 ? pos1 : ftp_r;
  assign same_nxt = same_r && (!b_flags_r.n3 || (pos1 == ftp_nxt));
  assign same_fin = same_nxt && (pos2 == ftp_nxt) && (pos3 == ftp_nxt);
  assign area_nxt = area_r + (b_flags_r.n0 ? '0 : AREA_BITS'(b_e1_r));
  assign area_fin = area_nxt + AREA_BITS'(b_e2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_r <= '0;
      ftp_r  <= 1'b0;
      same_r <= 1'b1;
    end else if (b_adv) begin
      if (b_flags_r.last) begin
        area_r <= '0;
        ftp_r  <= 1'b0;
        same_r <= 1'b1;
      end else begin
        area_r <= area_nxt;
        ftp_r  <= ftp_nxt;
        same_r <= same_nxt;
      end
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (b_adv && b_flags_r.last) begin
      o_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      o_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && b_flags_r.last) begin
      if (b_flags_r.close) begin
        o_area_r   <= area_fin;
        o_minx_r   <= b_minx_r;
        o_miny_r   <= b_miny_r;
        o_w_r      <= COORD_BITS'(b_maxx_r - b_minx_r);
        o_h_r      <= COORD_BITS'(b_maxy_r - b_miny_r);
        o_convex_r <= same_fin;
        o_valid_r  <= 1'b1;
      end else begin
        o_area_r   <= '0;
        o_minx_r   <= '0;
        o_miny_r   <= '0;
        o_w_r      <= '0;
        o_h_r      <= '0;
        o_convex_r <= 1'b0;
        o_valid_r  <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = o_vld_r;
  assign out_ch.twice_area = o_area_r;
  assign out_ch.min_x      = o_minx_r;
  assign out_ch.min_y      = o_miny_r;
  assign out_ch.box_width  = o_w_r;
  assign out_ch.box_height = o_h_r;
  assign out_ch.convex     = o_convex_r;
  assign out_ch.valid_res  = o_valid_r;

  // ---- assertions ----
  a_reject_zero : assert property (@(posedge clk) disable iff (!rst_n)
    o_vld_r && !o_valid_r |-> (o_area_r == '0) && !o_convex_r && (o_w_r == '0))
    else $error("rejected polygon carries nonzero result fields");

  a_count_clear : assert property (@(posedge clk) disable iff (!rst_n)
    a_adv && a_last_r |=> (cnt_r == '0))
    else $error("vertex count not cleared after last vertex");

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> a_vld_r && b_vld_r && b_flags_r.last && o_vld_r && !out_ch.ready)
    else $error("input stalled without a blocked result");

  a_poly_state_clear : assert property (@(posedge clk) disable iff (!rst_n)
    b_adv && b_flags_r.last |=> (area_r == '0) && same_r && !ftp_r)
    else $error("polygon state not cleared after result");

endmodule
`default_nettype wire

// ===== bench/tb_polygon_area_bounds_convexity_core.sv =====
// ----------------------------------------------------------------------------
// tb_polygon_area_bounds_convexity_core: self-checking bench for the core
// Streams polygons of random size and shape through the vertex channel and
// compares every result word with an in-bench shoelace, bounding box and
// convexity tracker; all phases but the last idle both channels at random.
// ----------------------------------------------------------------------------
module tb_polygon_area_bounds_convexity_core import pabc_pkg::*; ();

  localparam int CB = 20;
  localparam int MAXV = 4096;
  localparam logic signed [CB-1:0] COORD_MIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic signed [CB-1:0] COORD_MAX = {1'b0, {(CB-1){1'b1}}};

  typedef struct packed {
    logic signed [AREA_BITS-1:0] twice_area;
    logic signed [CB-1:0]        min_x;
    logic signed [CB-1:0]        min_y;
    logic        [CB-1:0]        box_width;
    logic        [CB-1:0]        box_height;
    logic                        convex;
    logic                        valid_res;
  } polygon_measure_t;

  class polygon_measure_tracker;
    longint first_x, first_y, second_x, second_y;
    longint prev_x, prev_y, pprev_x, pprev_y;
    longint lo_x, hi_x, lo_y, hi_y;
    int unsigned vertex_count;
    logic [AREA_BITS-1:0] area_acc;
    bit ref_turn_pos, turns_agree;
    polygon_measure_t pending_measures[$];
    int errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      first_x = 0; first_y = 0; second_x = 0; second_y = 0;
      prev_x = 0; prev_y = 0; pprev_x = 0; pprev_y = 0;
      lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
      vertex_count = 0;
      area_acc = '0;
      ref_turn_pos = 1'b0;
      turns_agree = 1'b1;
    endfunction

    function longint turn_cross(longint ax, longint ay, longint bx, longint by,
                                longint cx, longint cy);
      return (bx - ax) * (cy - by) - (by - ay) * (cx - bx);
    endfunction

    function void add_edge(longint ax, longint ay, longint bx, longint by);
      longint term;
      term = (ax + bx) * (ay - by);
      area_acc = AREA_BITS'(area_acc + term);
    endfunction

    function void check_turn(longint zc);
      if ((zc > 0) != ref_turn_pos) turns_agree = 1'b0;
    endfunction

    function int pending_count();
      return pending_measures.size();
    endfunction

    function void note_vertex(logic signed [CB-1:0] vx, logic signed [CB-1:0] vy,
                              logic last);
      longint cx, cy, zc;
      int unsigned n;
      polygon_measure_t m;
      cx = longint'(vx);
      cy = longint'(vy);
      n = vertex_count;
      if (n == 0) begin
        first_x = cx; first_y = cy;
        lo_x = cx; hi_x = cx; lo_y = cy; hi_y = cy;
      end else begin
        add_edge(prev_x, prev_y, cx, cy);
        if (cx < lo_x) lo_x = cx;
        if (cx > hi_x) hi_x = cx;
        if (cy < lo_y) lo_y = cy;
        if (cy > hi_y) hi_y = cy;
      end
      if (n == 1) begin
        second_x = cx; second_y = cy;
      end
      if (n >= 2) begin
        zc = turn_cross(pprev_x, pprev_y, prev_x, prev_y, cx, cy);
        if (n == 2) ref_turn_pos = (zc > 0);
        else check_turn(zc);
      end
      pprev_x = prev_x; pprev_y = prev_y;
      prev_x = cx; prev_y = cy;
      if (n <= MAXV) vertex_count = n + 1;
      if (!last) return;
      m = '0;
      if (vertex_count >= 3 && vertex_count <= MAXV) begin
        add_edge(prev_x, prev_y, first_x, first_y);
        check_turn(turn_cross(pprev_x, pprev_y, prev_x, prev_y, first_x, first_y));
        check_turn(turn_cross(prev_x, prev_y, first_x, first_y, second_x, second_y));
        m.twice_area = area_acc;
        m.min_x = lo_x[CB-1:0];
        m.min_y = lo_y[CB-1:0];
        m.box_width = CB'(hi_x - lo_x);
        m.box_height = CB'(hi_y - lo_y);
        m.convex = turns_agree;
        m.valid_res = 1'b1;
      end
      pending_measures.push_back(m);
      restart();
    endfunction

    function void check_result(polygon_measure_t got);
      polygon_measure_t exp_m;
      if (pending_measures.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result word: area=%0d valid=%0b", got.twice_area,
                   got.valid_res);
        return;
      end
      exp_m = pending_measures.pop_front();
      if (got.twice_area !== exp_m.twice_area || got.min_x !== exp_m.min_x ||
          got.min_y !== exp_m.min_y || got.box_width !== exp_m.box_width ||
          got.box_height !== exp_m.box_height || got.convex !== exp_m.convex ||
          got.valid_res !== exp_m.valid_res) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch exp: area=%0d min=(%0d,%0d) size=%0dx%0d convex=%0b valid=%0b",
                   exp_m.twice_area, exp_m.min_x, exp_m.min_y, exp_m.box_width,
                   exp_m.box_height, exp_m.convex, exp_m.valid_res);
          $display("         got: area=%0d min=(%0d,%0d) size=%0dx%0d convex=%0b valid=%0b",
                   got.twice_area, got.min_x, got.min_y, got.box_width,
                   got.box_height, got.convex, got.valid_res);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int src_idle_pct;
  int sink_idle_pct;
  polygon_measure_tracker tracker;

  pabc_in_if #(.COORD_BITS(CB)) in_ch ();
  pabc_out_if #(.COORD_BITS(CB)) out_ch ();

  polygon_area_bounds_convexity_core #(
    .COORD_BITS(CB),
    .MAX_VERTICES(MAXV)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    polygon_measure_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        tracker.note_vertex(in_ch.vx, in_ch.vy, in_ch.last_vertex);
      if (out_ch.valid && out_ch.ready) begin
        got.twice_area = out_ch.twice_area;
        got.min_x = out_ch.min_x;
        got.min_y = out_ch.min_y;
        got.box_width = out_ch.box_width;
        got.box_height = out_ch.box_height;
        got.convex = out_ch.convex;
        got.valid_res = out_ch.valid_res;
        tracker.check_result(got);
      end
    end
  end

  task automatic send_vertex(input logic signed [CB-1:0] vx,
                             input logic signed [CB-1:0] vy, input logic last);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.vx <= vx;
    in_ch.vy <= vy;
    in_ch.last_vertex <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_xy(input int x, input int y, input logic last);
    send_vertex(CB'(x), CB'(y), last);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_count() != 0) @(posedge clk);
  endtask

  function automatic logic signed [CB-1:0] pick_extreme();
    case ($urandom_range(4))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '0;
      3: return '1;
      default: return CB'($urandom);
    endcase
  endfunction

  task automatic send_random_polygon(input int n);
    int kind, idx, ctr_x, ctr_y, rad, jit;
    bit rev;
    real ang;
    logic signed [CB-1:0] vx, vy;
    kind = $urandom_range(3);
    rev = 1'($urandom_range(1));
    ctr_x = $urandom_range(400000) - 200000;
    ctr_y = $urandom_range(400000) - 200000;
    rad = (n > 40) ? 300000 : $urandom_range(300000, 1);
    jit = $urandom_range(8);
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: begin
          vx = CB'($urandom);
          vy = CB'($urandom);
        end
        1: begin
          vx = CB'(ctr_x + $urandom_range(8) - 4);
          vy = CB'(ctr_y + $urandom_range(8) - 4);
        end
        2: begin
          idx = rev ? (n - 1 - i) : i;
          ang = 6.283185307179586 * (idx + jit / 10.0) / n;
          vx = CB'(ctr_x + $rtoi(rad * $cos(ang)));
          vy = CB'(ctr_y + $rtoi(rad * $sin(ang)));
        end
        default: begin
          vx = pick_extreme();
          vy = pick_extreme();
        end
      endcase
      send_vertex(vx, vy, i == n - 1);
    end
  endtask

  task automatic run_random_phase(input int budget);
    int sent, n, r;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(99);
      if (r < 6) n = $urandom_range(2, 1);
      else if (r < 85) n = $urandom_range(8, 3);
      else n = $urandom_range(40, 9);
      send_random_polygon(n);
      sent += n;
      if ($urandom_range(49) == 0) wait_for_results();
    end
  endtask

  task automatic send_directed();
    send_vertex(COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, 1'b1);
    send_vertex(COORD_MAX, COORD_MAX, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, 1'b0);
    send_vertex(COORD_MIN, COORD_MIN, 1'b1);
    // too few vertices
    send_vertex(COORD_MIN, COORD_MAX, 1'b1);
    send_xy(0, 0, 1'b0);
    send_xy(-1, -1, 1'b1);
    // collinear: every turn is zero
    send_xy(0, 0, 1'b0);
    send_xy(1, 1, 1'b0);
    send_xy(2, 2, 1'b1);
    send_xy(-100, -100, 1'b0);
    send_xy(100, -100, 1'b0);
    send_xy(100, 100, 1'b0);
    send_xy(-100, 100, 1'b1);
    // concave arrow
    send_xy(0, 0, 1'b0);
    send_xy(10, 5, 1'b0);
    send_xy(0, 10, 1'b0);
    send_xy(4, 5, 1'b1);
    // convex square with a straight midpoint
    send_xy(0, 0, 1'b0);
    send_xy(5, 0, 1'b0);
    send_xy(10, 0, 1'b0);
    send_xy(10, 10, 1'b0);
    send_xy(0, 10, 1'b1);
  endtask

  initial begin
    #12000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.vx = '0;
    in_ch.vy = '0;
    in_ch.last_vertex = 1'b0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    src_idle_pct = 33;
    sink_idle_pct = 83;
    tracker = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_directed();
    run_random_phase(530);
    wait_for_results();
    src_idle_pct = 83;
    sink_idle_pct = 33;
    run_random_phase(530);
    wait_for_results();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    run_random_phase(540);
    wait_for_results();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
